>>> rtl/core/amsrm_pkg.sv
// Shared types, constants and helper functions for the affine matrix builder.
package amsrm_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CS_USED      = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    localparam int TRIG_W       = 20;
    localparam int Z_W          = 20;

    localparam logic signed [15:0] TURN_UNITS   = 16'sd23040;
    localparam logic signed [15:0] HALF_TURN    = 16'sd11520;
    localparam logic signed [15:0] QUARTER_TURN = 16'sd5760;
    localparam logic [20:0]        RAD_PER_UNIT = 21'd1171271;
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 20'sd39797;
    localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

    typedef logic signed [TRIG_W-1:0] t_trig;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] sz;
        logic signed [31:0] mx;
        logic signed [31:0] my;
        logic signed [31:0] mz;
    } t_side;

    function automatic logic signed [Z_W-1:0] atan_q16(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0: v = 20'sd51472;
            1: v = 20'sd30386;
            2: v = 20'sd16055;
            3: v = 20'sd8150;
            4: v = 20'sd4091;
            5: v = 20'sd2047;
            6: v = 20'sd1024;
            7: v = 20'sd512;
            8: v = 20'sd256;
            9: v = 20'sd128;
            10: v = 20'sd64;
            11: v = 20'sd32;
            12: v = 20'sd16;
            13: v = 20'sd8;
            14: v = 20'sd4;
            15: v = 20'sd2;
            16: v = 20'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sh0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
        else if (v < -48'sh0000_8000_0000) r = 32'sh8000_0000;
        else r = v[31:0];
        return r;
    endfunction

endpackage

>>> rtl/core/amsrm_sincos.sv
// Pipelined angle reduction and CORDIC sine/cosine, one step per stage.
module amsrm_sincos import amsrm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_angle,
    output t_trig              o_sin,
    output t_trig              o_cos
);
    logic signed [16:0] w0, w1;
    logic signed [16:0] red;
    logic               negc;
    logic [13:0]        mag;
    logic [34:0]        prod;
    logic signed [Z_W-1:0] z0;

    logic signed [Z_W-1:0] r_z  [0:CS_USED];
    t_trig                 r_x  [0:CS_USED];
    t_trig                 r_y  [0:CS_USED];
    logic                  r_nc [0:CS_USED];

    always_comb begin
        w0 = {i_angle[15], i_angle};
        if (w0 > 17'(HALF_TURN)) w1 = w0 - 17'(TURN_UNITS);
        else if (w0 <= -17'(HALF_TURN)) w1 = w0 + 17'(TURN_UNITS);
        else w1 = w0;
        negc = 1'b0;
        red  = w1;
        if (w1 > 17'(QUARTER_TURN)) begin
            red = 17'(HALF_TURN) - w1; negc = 1'b1;
        end else if (w1 < -17'(QUARTER_TURN)) begin
            red = -17'(HALF_TURN) - w1; negc = 1'b1;
        end
        mag  = red[16] ? 14'(-red) : 14'(red);
        prod = 35'(mag) * 35'(RAD_PER_UNIT) + 35'd32768;
        z0   = red[16] ? -Z_W'(prod[34:16]) : Z_W'(prod[34:16]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z[0]  <= z0;
            r_x[0]  <= CORDIC_GAIN;
            r_y[0]  <= '0;
            r_nc[0] <= negc;
        end
    end

    for (genvar g = 0; g < CS_USED; g++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nc[g+1] <= r_nc[g];
                if (r_z[g] >= 0) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - atan_q16(g);
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + atan_q16(g);
                end
            end
        end
    end

    assign o_sin = r_y[CS_USED];
    assign o_cos = r_nc[CS_USED] ? -r_x[CS_USED] : r_x[CS_USED];
endmodule

>>> rtl/core/amsrm_matrix.sv
// Rotation matrix products and row scaling, registered stage by stage.
module amsrm_matrix import amsrm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  t_trig       i_sx, i_cx, i_sy, i_cy, i_sz, i_cz,
    input  t_side       i_side,
    output logic [95:0] o_row0,
    output logic [95:0] o_row1,
    output logic [95:0] o_row2,
    output t_side       o_side
);
    // stage A: products of Ry*Rz
    logic signed [39:0] r_cycz, r_cysz, r_sycz, r_sysz;
    t_trig r_a_sx, r_a_cx, r_a_sy, r_a_cy, r_a_sz, r_a_cz;
    t_side r_a_side;
    // stage B: round Ry*Rz
    t_trig r_b00, r_b01, r_b02, r_b10, r_b11, r_b20, r_b21, r_b22;
    t_trig r_b_sx, r_b_cx;
    t_side r_b_side;
    // stage C: Rx products
    logic signed [39:0] r_p11, r_p12, r_p13, r_p14, r_p16;
    logic signed [39:0] r_q11, r_q12, r_q13, r_q14, r_q15;
    t_trig r_c00, r_c01, r_c02;
    t_side r_c_side;
    // stage D: final R
    t_trig r_r [0:2][0:2];
    t_side r_d_side;
    // stage E: scaled products
    logic signed [51:0] r_e [0:2][0:2];
    t_side r_e_side;

    function automatic t_trig rnd(input logic signed [40:0] v);
        logic signed [40:0] t;
        t = v + 41'sd32768;
        return TRIG_W'(t >>> 16);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cycz <= 40'(i_cy) * 40'(i_cz);
            r_cysz <= 40'(i_cy) * 40'(i_sz);
            r_sycz <= 40'(i_sy) * 40'(i_cz);
            r_sysz <= 40'(i_sy) * 40'(i_sz);
            r_a_sx <= i_sx; r_a_cx <= i_cx; r_a_sy <= i_sy; r_a_cy <= i_cy;
            r_a_sz <= i_sz; r_a_cz <= i_cz;
            r_a_side <= i_side;

            // ryz = [cycz cysz sy; -sz cz 0; -sycz -sysz cy]
            r_b00 <= rnd(41'(r_cycz));
            r_b01 <= rnd(41'(r_cysz));
            r_b02 <= r_a_sy;
            r_b10 <= -r_a_sz;
            r_b11 <= r_a_cz;
            r_b20 <= rnd(-41'(r_sycz));
            r_b21 <= rnd(-41'(r_sysz));
            r_b22 <= r_a_cy;
            r_b_sx <= r_a_sx; r_b_cx <= r_a_cx;
            r_b_side <= r_a_side;

            r_p11 <= 40'(r_b_cx) * 40'(r_b10);
            r_p12 <= 40'(r_b_sx) * 40'(r_b20);
            r_p13 <= 40'(r_b_cx) * 40'(r_b11);
            r_p14 <= 40'(r_b_sx) * 40'(r_b21);
            r_p16 <= 40'(r_b_sx) * 40'(r_b22);
            r_q11 <= -(40'(r_b_sx) * 40'(r_b10));
            r_q12 <= 40'(r_b_cx) * 40'(r_b20);
            r_q13 <= -(40'(r_b_sx) * 40'(r_b11));
            r_q14 <= 40'(r_b_cx) * 40'(r_b21);
            r_q15 <= 40'(r_b_cx) * 40'(r_b22);
            r_c00 <= r_b00; r_c01 <= r_b01; r_c02 <= r_b02;
            r_c_side <= r_b_side;

            r_r[0][0] <= r_c00; r_r[0][1] <= r_c01; r_r[0][2] <= r_c02;
            r_r[1][0] <= rnd(41'(r_p11) + 41'(r_p12));
            r_r[1][1] <= rnd(41'(r_p13) + 41'(r_p14));
            r_r[1][2] <= rnd(41'(r_p16));
            r_r[2][0] <= rnd(41'(r_q11) + 41'(r_q12));
            r_r[2][1] <= rnd(41'(r_q13) + 41'(r_q14));
            r_r[2][2] <= rnd(41'(r_q15));
            r_d_side <= r_c_side;

            for (int j = 0; j < 3; j++) begin
                r_e[0][j] <= 52'(r_d_side.sx) * 52'(r_r[0][j]);
                r_e[1][j] <= 52'(r_d_side.sy) * 52'(r_r[1][j]);
                r_e[2][j] <= 52'(r_d_side.sz) * 52'(r_r[2][j]);
            end
            r_e_side <= r_d_side;
        end
    end

    function automatic logic [31:0] scl(input logic signed [51:0] v);
        logic signed [51:0] t;
        t = (v + 52'sd32768) >>> 16;
        return sat32(48'(t));
    endfunction

    logic [31:0] c [0:2][0:2];
    always_comb begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                c[i][j] = scl(r_e[i][j]);
    end
    assign o_row0 = {c[0][2], c[0][1], c[0][0]};
    assign o_row1 = {c[1][2], c[1][1], c[1][0]};
    assign o_row2 = {c[2][2], c[2][1], c[2][0]};
    assign o_side = r_e_side;
endmodule

>>> rtl/core/affine_matrix_from_scale_rotate_move.sv
// Top level: affine matrix builder, stream in, four row words out.
// Takes new words while older ones are in flight; each gives four row words.
// Throughput: output one row per cycle while m_axis_tready is high.
// Pipeline advances whenever its tail slot is free; stalls lose nothing.
// Reset (synchronous, active low) clears valid bits and the row sequencer.
module affine_matrix_from_scale_rotate_move import amsrm_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // scale_x, scale_y, scale_z, angle_x, angle_y, angle_z, move_x, move_y, move_z
    input  logic [239:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // row_index[1:0], col0, col1, col2, col3, zero pad
    output logic [135:0] m_axis_tdata,
    output logic         m_axis_tlast
);
    localparam int LAT = CS_USED + 6;

    logic  en;
    logic  r_v [0:LAT-1];
    t_side side_in, side_out;
    t_trig sx, cx, sy, cy, sz, cz;
    logic [95:0] row0, row1, row2;

    logic        r_ov;
    logic [1:0]  r_ri;
    logic [95:0] r_hold0, r_hold1, r_hold2;
    t_side       r_hs;

    assign side_in = '{sx: s_axis_tdata[31:0], sy: s_axis_tdata[63:32],
                       sz: s_axis_tdata[95:64], mx: s_axis_tdata[175:144],
                       my: s_axis_tdata[207:176], mz: s_axis_tdata[239:208]};

    logic out_free;
    assign out_free = !r_ov || (m_axis_tready && r_ri == 2'd3);
    assign en = !r_v[LAT-1] || out_free;
    assign s_axis_tready = en;

    amsrm_sincos u_scx (.i_clk, .i_en(en), .i_angle(s_axis_tdata[111:96]),
                        .o_sin(sx), .o_cos(cx));
    amsrm_sincos u_scy (.i_clk, .i_en(en), .i_angle(s_axis_tdata[127:112]),
                        .o_sin(sy), .o_cos(cy));
    amsrm_sincos u_scz (.i_clk, .i_en(en), .i_angle(s_axis_tdata[143:128]),
                        .o_sin(sz), .o_cos(cz));

    t_side r_sd [0:CS_USED];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[0] <= side_in;
            for (int k = 0; k < CS_USED; k++) r_sd[k+1] <= r_sd[k];
        end
    end

    amsrm_matrix u_mat (.i_clk, .i_en(en), .i_sx(sx), .i_cx(cx), .i_sy(sy),
                        .i_cy(cy), .i_sz(sz), .i_cz(cz), .i_side(r_sd[CS_USED]),
                        .o_row0(row0), .o_row1(row1), .o_row2(row2),
                        .o_side(side_out));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_v[k] <= 1'b0;
        end else if (en) begin
            r_v[0] <= s_axis_tvalid;
            for (int k = 1; k < LAT; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_ri <= 2'd0;
        end else if (r_ov && m_axis_tready && r_ri != 2'd3) begin
            r_ri <= r_ri + 2'd1;
        end else if (out_free) begin
            r_ov <= r_v[LAT-1];
            r_ri <= 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_v[LAT-1]) begin
            r_hold0 <= row0; r_hold1 <= row1; r_hold2 <= row2;
            r_hs <= side_out;
        end
    end

    logic [127:0] cols;
    always_comb begin
        case (r_ri)
            2'd0:    cols = {32'd0, r_hold0};
            2'd1:    cols = {32'd0, r_hold1};
            2'd2:    cols = {32'd0, r_hold2};
            default: cols = {ONE_Q16, r_hs.mz, r_hs.my, r_hs.mx};
        endcase
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {6'd0, cols, r_ri};
    assign m_axis_tlast  = (r_ri == 2'd3);

`ifndef NO_ASSERTIONS
    a_tlast_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[1:0] == 2'd3)))
        else $error("tlast out of step with row index");
    a_row_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tvalid && m_axis_tdata[1:0] == $past(m_axis_tdata[1:0]) + 2'd1))
        else $error("row sequence broken");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("output word dropped");
`endif
endmodule
